// File: sv/cimd_pkg.sv
// ----------------------------------------------------------------------------
// cimd_pkg
// Shared types and constants for the cascaded interrupt mask and dispatch
// unit: command and group codes, request, mask and result records.
// ----------------------------------------------------------------------------
package cimd_pkg;

    localparam int GPIO_PINS = 32;
    localparam int HALF_BITS = 16;

    localparam logic [15:0] CASCADE_SELECT = 16'h01ff;
    localparam logic [15:0] CASCADE_BIT    = 16'h0100;
    localparam logic [15:0] LEVEL_ONE_BIT  = 16'h0001;

    // Valid pins of the GPIO mask, and the pin count as a 6-bit compare limit
    localparam logic [31:0] GPIO_VALID = 32'((64'd1 << GPIO_PINS) - 64'd1);
    localparam logic [5:0]  PIN_LIMIT  = 6'(GPIO_PINS);

    typedef enum logic [1:0] {
        CMD_ENABLE   = 2'd0,
        CMD_DISABLE  = 2'd1,
        CMD_DISPATCH = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        GRP_LEVEL1 = 2'd0,
        GRP_LEVEL2 = 2'd1,
        GRP_GPIO   = 2'd2,
        GRP_NONE   = 2'd3
    } grp_t;

    typedef struct packed {
        cmd_t        cmd;
        grp_t        line_group;
        logic [4:0]  line_bit;
        logic [15:0] level1_pending;
        logic [15:0] level2_pending;
        logic [15:0] gpio_low_pending;
        logic [15:0] gpio_high_pending;
    } req_t;

    typedef struct packed {
        logic [15:0] level1;
        logic [15:0] level2;
        logic [31:0] gpio;
    } masks_t;

    typedef struct packed {
        logic        found;
        grp_t        found_group;
        logic [4:0]  found_bit;
    } hit_t;

endpackage

// File: sv/cimd_mask_regs.sv
// ----------------------------------------------------------------------------
// cimd_mask_regs
// Mask state: level one, level two and GPIO masks with the read-modify-write
// of enable and disable requests. Returns the updated 16-bit mask word on an
// enable or disable of a level or GPIO group, zero otherwise.
module cimd_mask_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            upd,
    input  cimd_pkg::req_t  req,
    output cimd_pkg::masks_t masks,
    output logic [15:0]     mask_word
);
    import cimd_pkg::*;

    logic [15:0] level1_mask_reg;
    logic [15:0] level1_mask_next;
    logic [15:0] level2_mask_reg;
    logic [15:0] level2_mask_next;
    logic [31:0] gpio_mask_reg;
    logic [31:0] gpio_mask_next;
    logic        set_bit;

    always_comb
    begin
        level1_mask_next = level1_mask_reg;
        level2_mask_next = level2_mask_reg;
        gpio_mask_next   = gpio_mask_reg;
        mask_word        = 16'd0;
        set_bit          = (req.cmd == CMD_ENABLE);
        if (req.cmd == CMD_ENABLE || req.cmd == CMD_DISABLE)
        begin
            case (req.line_group)
                GRP_LEVEL1:
                begin
                    // level bits 16 and up leave the word unchanged
                    if (!req.line_bit[4])
                    begin
                        level1_mask_next[req.line_bit[3:0]] = set_bit;
                    end
                    mask_word = level1_mask_next;
                end
                GRP_LEVEL2:
                begin
                    if (!req.line_bit[4])
                    begin
                        level2_mask_next[req.line_bit[3:0]] = set_bit;
                    end
                    mask_word = level2_mask_next;
                end
                GRP_GPIO:
                begin
                    if ({1'b0, req.line_bit} < PIN_LIMIT)
                    begin
                        gpio_mask_next[req.line_bit] = set_bit;
                        gpio_mask_next = gpio_mask_next & GPIO_VALID;
                    end
                    // return the half word that holds the pin
                    mask_word = req.line_bit[4] ? gpio_mask_next[31:16]
                                                : gpio_mask_next[15:0];
                end
                default:
                begin
                    mask_word = 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level1_mask_reg <= 16'd0;
            level2_mask_reg <= 16'd0;
            gpio_mask_reg   <= 32'd0;
        end
        else if (upd)
        begin
            level1_mask_reg <= level1_mask_next;
            level2_mask_reg <= level2_mask_next;
            gpio_mask_reg   <= gpio_mask_next;
        end
    end

    assign masks.level1 = level1_mask_reg;
    assign masks.level2 = level2_mask_reg;
    assign masks.gpio   = gpio_mask_reg;

`ifndef SYNTHESIS
    a_gpio_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (gpio_mask_reg & ~GPIO_VALID) == 32'd0)
        else $error("gpio mask holds bits beyond the pin count");

    a_hold_without_update: assert property (@(posedge clk) disable iff (!rst_n)
        !upd |=> ($stable(level1_mask_reg) && $stable(level2_mask_reg)
                  && $stable(gpio_mask_reg)))
        else $error("mask changed without an update");

    a_dispatch_keeps_masks: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && req.cmd == CMD_DISPATCH) |=> ($stable(level1_mask_reg)
            && $stable(level2_mask_reg) && $stable(gpio_mask_reg)))
        else $error("dispatch request modified a mask");
`endif

endmodule

// File: sv/cimd_prio.sv
// ----------------------------------------------------------------------------
// cimd_prio
// Dispatch priority: masks the pending words, serves level one first with
// the GPIO cascade on bit 8, then level two, lowest set bit wins.
// ----------------------------------------------------------------------------
module cimd_prio (
    input  cimd_pkg::req_t   req,
    input  cimd_pkg::masks_t masks,
    output cimd_pkg::hit_t   hit
);
    import cimd_pkg::*;

    logic [15:0] m1;
    logic [15:0] m2;
    logic [15:0] gl;
    logic [15:0] gh;

    function automatic logic [3:0] lowest_bit(input logic [15:0] w);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = HALF_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    always_comb
    begin
        m1 = req.level1_pending & masks.level1;
        m2 = req.level2_pending & masks.level2;
        gl = req.gpio_low_pending & masks.gpio[15:0];
        gh = req.gpio_high_pending & masks.gpio[31:16];
        hit.found       = 1'b0;
        hit.found_group = GRP_LEVEL1;
        hit.found_bit   = 5'd0;
        if (req.cmd == CMD_DISPATCH)
        begin
            if (m1 != 16'd0)
            begin
                // cascade only when bit 8 is the sole one among bits 0..8
                if ((m1 & CASCADE_SELECT) == CASCADE_BIT)
                begin
                    if (gl != 16'd0)
                    begin
                        hit.found       = 1'b1;
                        hit.found_group = GRP_GPIO;
                        hit.found_bit   = {1'b0, lowest_bit(gl)};
                    end
                    else if (gh != 16'd0)
                    begin
                        hit.found       = 1'b1;
                        hit.found_group = GRP_GPIO;
                        hit.found_bit   = {1'b1, lowest_bit(gh)};
                    end
                end
                else
                begin
                    hit.found       = 1'b1;
                    hit.found_group = GRP_LEVEL1;
                    hit.found_bit   = {1'b0, lowest_bit(m1)};
                end
            end
            else if (m2 != 16'd0)
            begin
                hit.found       = 1'b1;
                hit.found_group = GRP_LEVEL2;
                hit.found_bit   = {1'b0, lowest_bit(m2)};
            end
        end
    end

endmodule

// File: sv/cascaded_interrupt_mask_dispatch.sv
// Path: an accepted request goes through the input register, then the result
// register, which drives m_tdata.
// Throughput: one request per cycle unless m_tready stalls the output; the
// mask update and priority encode of one request sit between the two registers.
// Reset: rst_n clears all three masks (every line masked) and both valid flags.
// ----------------------------------------------------------------------------
// cascaded_interrupt_mask_dispatch
// Interrupt mask and dispatch unit with a level one, level two and cascaded
// GPIO mask; enable, disable and dispatch requests over a stream interface.
// ----------------------------------------------------------------------------
module cascaded_interrupt_mask_dispatch (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] line_group, [6:2] line_bit, [22:7] level1_pending,
    // [38:23] level2_pending, [54:39] gpio_low_pending,
    // [70:55] gpio_high_pending, [71] zero
    input  logic [71:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] found, [2:1] found_group, [7:3] found_bit, [23:8] mask_word
    output logic [23:0] m_tdata
);
    import cimd_pkg::*;

    logic        in_valid_reg;
    req_t        in_req_reg;
    logic        out_valid_reg;
    hit_t        out_hit_reg;
    logic [15:0] out_word_reg;
    logic        advance;
    req_t        s_req;
    masks_t      masks;
    hit_t        hit;
    logic [15:0] mask_word;

    assign s_req.cmd               = cmd_t'(s_tuser);
    assign s_req.line_group        = grp_t'(s_tdata[1:0]);
    assign s_req.line_bit          = s_tdata[6:2];
    assign s_req.level1_pending    = s_tdata[22:7];
    assign s_req.level2_pending    = s_tdata[38:23];
    assign s_req.gpio_low_pending  = s_tdata[54:39];
    assign s_req.gpio_high_pending = s_tdata[70:55];

    // advance the input stage when the result register is free or draining
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    cimd_mask_regs u_mask (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (in_valid_reg && advance),
        .req       (in_req_reg),
        .masks     (masks),
        .mask_word (mask_word)
    );

    cimd_prio u_prio (
        .req   (in_req_reg),
        .masks (masks),
        .hit   (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg <= s_req;
        end
        if (advance && in_valid_reg)
        begin
            out_hit_reg  <= hit;
            out_word_reg <= mask_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_word_reg, out_hit_reg.found_bit,
                       out_hit_reg.found_group, out_hit_reg.found};

`ifndef SYNTHESIS
    a_word_or_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg.found && out_word_reg != 16'd0))
        else $error("result carries both a dispatched line and a mask word");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg.found) |->
            (out_hit_reg.found_group == GRP_LEVEL1 && out_hit_reg.found_bit == 5'd0))
        else $error("empty dispatch result has nonzero line fields");

    a_stalled_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_req_reg)))
        else $error("stalled request lost from input register");

    a_level_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hit_reg.found && out_hit_reg.found_group != GRP_GPIO)
            |-> !out_hit_reg.found_bit[4])
        else $error("level line index beyond sixteen");
`endif

endmodule
